// ----- rtl/core/gcol_pkg.sv -----
// Shared types and constants for the greedy graph colorer.
// Used by gcol_ctrl, gcol_dp and greedy_graph_colorer; depends on nothing.
`default_nettype none

package gcol_pkg;

  localparam int COLOR_W    = 8;
  localparam int VERTEX_W   = 8;
  localparam int VCOUNT_W   = 9;
  localparam int NUM_COLORS = 256;
  localparam int GRP_W      = 16;
  localparam int NUM_GRPS   = NUM_COLORS / GRP_W;
  localparam int GRP_IDX_W  = 4;
  localparam int BIT_IDX_W  = 4;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 9'd256;
  localparam logic [COLOR_W-1:0]  COLOR_SAT    = 8'd255;

  localparam logic [1:0] OP_ADD_EDGE = 2'd0;
  localparam logic [1:0] OP_COLOR    = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef struct packed {
    logic [1:0]          op;
    logic [VERTEX_W-1:0] vertex_a;
    logic [VERTEX_W-1:0] vertex_b;
  } gcol_in_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] colored_vertex;
    logic [COLOR_W-1:0]  assigned_color;
    logic [VCOUNT_W-1:0] colors_used;
  } gcol_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic clr_start;
    logic clr_step;
    logic edge_rd_a;
    logic edge_wr_a;
    logic edge_wr_b;
    logic row_rd;
    logic scan_start;
    logic scan_step;
    logic grp_eval;
    logic grp_sel;
    logic pick;
    logic commit;
  } gcol_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic edge_ok;
    logic color_ok;
    logic clear_req;
    logic clr_last;
    logic scan_done;
    logic out_free;
  } gcol_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/gcol_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Read-during-write to the same address returns the old data; no dependencies.
`default_nettype none

module gcol_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/core/gcol_ctrl.sv -----
// Controller state machine of the greedy graph colorer.
// Sequences clear sweeps, edge updates and color scans; uses gcol_pkg.
`default_nettype none

module gcol_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire gcol_pkg::gcol_sts_t  sts,
  output gcol_pkg::gcol_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_EDGE_A,
    S_EDGE_B,
    S_EDGE_W,
    S_ROW_RD,
    S_ROW_LD,
    S_SCAN,
    S_GRP,
    S_SEL,
    S_PICK,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.edge_ok) begin
          state_nxt = S_EDGE_A;
        end else if (sts.color_ok) begin
          state_nxt = S_ROW_RD;
        end else if (sts.clear_req) begin
          cmd.clr_start = 1'b1;
          state_nxt     = S_CLEAR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EDGE_A: begin
        cmd.edge_rd_a = 1'b1;
        state_nxt     = S_EDGE_B;
      end
      S_EDGE_B: begin
        cmd.edge_wr_a = 1'b1;
        state_nxt     = S_EDGE_W;
      end
      S_EDGE_W: begin
        cmd.edge_wr_b = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_ROW_RD: begin
        cmd.row_rd = 1'b1;
        state_nxt  = S_ROW_LD;
      end
      S_ROW_LD: begin
        cmd.scan_start = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_GRP;
      end
      S_GRP: begin
        cmd.grp_eval = 1'b1;
        state_nxt    = S_SEL;
      end
      S_SEL: begin
        cmd.grp_sel = 1'b1;
        state_nxt   = S_PICK;
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

`default_nettype wire

// ----- rtl/core/gcol_dp.sv -----
// Datapath of the greedy graph colorer: adjacency and color memories, scan
// counter, blocked-color vector, free-color search and result register.
// Uses gcol_pkg and gcol_ram.
`default_nettype none

module gcol_dp #(
  parameter int MAX_VERTICES = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire gcol_pkg::gcol_cmd_t                 cmd,
  output gcol_pkg::gcol_sts_t                      sts,
  input  wire gcol_pkg::gcol_in_t                  in_data,
  input  wire logic [gcol_pkg::VCOUNT_W-1:0]       vertex_count,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output gcol_pkg::gcol_out_t                      out_data
);

  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int CNTW = VW + 1;
  localparam int EW   = (CNTW > gcol_pkg::VCOUNT_W) ? CNTW : gcol_pkg::VCOUNT_W;
  localparam int CW   = gcol_pkg::COLOR_W;

  typedef logic [MAX_VERTICES-1:0] row_t;

  gcol_pkg::gcol_in_t  item_r;
  logic [CNTW-1:0]     cnt_r;
  logic [CNTW-1:0]     live_cnt;
  logic                pend_r;
  row_t                row_r;
  logic [gcol_pkg::NUM_COLORS-1:0] blocked_r;
  logic [gcol_pkg::NUM_GRPS-1:0]   grp_full_r;
  logic [gcol_pkg::GRP_IDX_W-1:0]  grp_sel_r, grp_sel_nxt;
  logic                all_full_r;
  logic [CW-1:0]       color_r, color_nxt;
  logic [CW-1:0]       hi_r, hi_nxt;
  logic                out_valid_r;
  gcol_pkg::gcol_out_t out_data_r;

  logic [VW-1:0]       va_idx, vb_idx, cnt_idx;
  logic                scan_issue, scan_use;
  logic [gcol_pkg::GRP_W-1:0]      grp_word;
  logic [gcol_pkg::BIT_IDX_W-1:0]  bit_sel;

  logic                adj_we, adj_re;
  logic [VW-1:0]       adj_waddr, adj_raddr;
  row_t                adj_wdata, adj_rdata;
  logic                col_we;
  logic [VW-1:0]       col_waddr;
  logic [CW:0]         col_wdata, col_rdata;

  // Number of vertices in use, limited to the storage size.
  assign live_cnt = (EW'(vertex_count) >= EW'(MAX_VERTICES)) ? CNTW'(MAX_VERTICES)
                                                           : CNTW'(vertex_count);

  assign va_idx  = VW'(item_r.vertex_a);
  assign vb_idx  = VW'(item_r.vertex_b);
  assign cnt_idx = cnt_r[VW-1:0];

  assign sts.edge_ok   = (item_r.op == gcol_pkg::OP_ADD_EDGE) &&
                         (EW'(item_r.vertex_a) < EW'(live_cnt)) &&
                         (EW'(item_r.vertex_b) < EW'(live_cnt));
  assign sts.color_ok  = (item_r.op == gcol_pkg::OP_COLOR) &&
                         (EW'(item_r.vertex_a) < EW'(live_cnt));
  assign sts.clear_req = (item_r.op == gcol_pkg::OP_CLEAR);
  assign sts.clr_last  = (cnt_r == CNTW'(MAX_VERTICES - 1));
  assign sts.scan_done = (cnt_r == live_cnt) && !pend_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  // Adjacency rows: one read-modify-write per endpoint of a new edge.
  assign adj_re    = cmd.edge_rd_a || cmd.edge_wr_a || cmd.row_rd;
  assign adj_raddr = cmd.edge_wr_a ? vb_idx : va_idx;
  assign adj_we    = cmd.edge_wr_a || cmd.edge_wr_b || cmd.clr_step;
  assign adj_waddr = cmd.clr_step ? cnt_idx : (cmd.edge_wr_b ? vb_idx : va_idx);
  assign adj_wdata = cmd.clr_step ? '0
                   : (adj_rdata | (row_t'(1) << (cmd.edge_wr_b ? va_idx : vb_idx)));

  gcol_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .re    (adj_re),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  // Color store: the top bit marks a colored vertex.
  assign scan_issue = cmd.scan_step && (cnt_r != live_cnt);
  assign scan_use   = cmd.scan_step && pend_r;
  assign col_we     = cmd.clr_step || cmd.commit;
  assign col_waddr  = cmd.clr_step ? cnt_idx : va_idx;
  assign col_wdata  = cmd.clr_step ? '0 : {1'b1, color_r};

  gcol_ram #(
    .WIDTH (CW + 1),
    .DEPTH (MAX_VERTICES)
  ) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (col_wdata),
    .re    (scan_issue),
    .raddr (cnt_idx),
    .rdata (col_rdata)
  );

  // First group of sixteen colors that still has a free one.
  always_comb begin
    grp_sel_nxt = '0;
    for (int g = gcol_pkg::NUM_GRPS - 1; g >= 0; g--) begin
      if (!grp_full_r[g]) grp_sel_nxt = gcol_pkg::GRP_IDX_W'(g);
    end
  end

  assign grp_word = blocked_r[grp_sel_r * gcol_pkg::GRP_W +: gcol_pkg::GRP_W];

  always_comb begin
    bit_sel = '0;
    for (int b = gcol_pkg::GRP_W - 1; b >= 0; b--) begin
      if (!grp_word[b]) bit_sel = gcol_pkg::BIT_IDX_W'(b);
    end
    color_nxt = all_full_r ? gcol_pkg::COLOR_SAT : {grp_sel_r, bit_sel};
  end

  assign hi_nxt = (color_r > hi_r) ? color_r : hi_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_data;

    if (cmd.scan_start) begin
      row_r     <= adj_rdata;
      blocked_r <= '0;
    end else if (scan_use) begin
      row_r <= row_r >> 1;
      if (row_r[0] && col_rdata[CW]) blocked_r[col_rdata[CW-1:0]] <= 1'b1;
    end

    if (cmd.grp_eval) begin
      for (int g = 0; g < gcol_pkg::NUM_GRPS; g++) begin
        grp_full_r[g] <= &blocked_r[g * gcol_pkg::GRP_W +: gcol_pkg::GRP_W];
      end
    end
    if (cmd.grp_sel) begin
      grp_sel_r  <= grp_sel_nxt;
      all_full_r <= &grp_full_r;
    end
    if (cmd.pick) color_r <= color_nxt;

    if (cmd.commit) begin
      out_data_r.colored_vertex <= item_r.vertex_a;
      out_data_r.assigned_color <= color_r;
      out_data_r.colors_used    <= gcol_pkg::VCOUNT_W'(hi_nxt) + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      hi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_start || cmd.scan_start) begin
        cnt_r <= '0;
      end else if (cmd.clr_step || scan_issue) begin
        cnt_r <= cnt_r + CNTW'(1);
      end

      if (cmd.scan_start) begin
        pend_r <= 1'b0;
      end else if (cmd.scan_step) begin
        pend_r <= scan_issue;
      end

      if (cmd.clr_start || cmd.clr_step) begin
        hi_r <= '0;
      end else if (cmd.commit) begin
        hi_r <= hi_nxt;
      end

      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/greedy_graph_colorer.sv -----
// Greedy graph colorer top level: configuration register, controller and datapath.
// Uses gcol_pkg, gcol_ctrl and gcol_dp.
`default_nettype none

// The block holds an undirected graph of up to MAX_VERTICES vertices as one
// adjacency row per vertex in memory, plus a color per vertex. Op 0 adds an
// edge (ignored if an endpoint is at or above vertex_count), op 1 colors
// vertex_a with the smallest color no colored neighbor holds (255 if all are
// held) and returns one result, op 2 clears the graph and all colors. One
// item is worked on at a time. Adding an edge does two read-modify-writes on
// the adjacency memory. Coloring decodes the item, fetches the adjacency row,
// scans the color memory once per vertex in use (vertex_count limited to
// MAX_VERTICES), runs the first-free-color search, writes the color and loads
// the result, and goes back to idle. A clear sweeps both memories one row per
// cycle; a clearing pass after reset runs before the first transfer. Ignored
// items and op 3 are only decoded. The result register lets the next item be
// accepted while a result waits for out_ready; a coloring that finishes while
// a result still waits stalls until that result leaves.
module greedy_graph_colorer #(
  parameter int MAX_VERTICES = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire gcol_pkg::gcol_in_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output gcol_pkg::gcol_out_t       out_data,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  logic [gcol_pkg::VCOUNT_W-1:0] vcount_r;
  gcol_pkg::gcol_cmd_t           cmd;
  gcol_pkg::gcol_sts_t           sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= gcol_pkg::VCOUNT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == gcol_pkg::REG_VERTEX_COUNT)) begin
      vcount_r <= pwdata[gcol_pkg::VCOUNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == gcol_pkg::REG_VERTEX_COUNT) ? 32'(vcount_r) : 32'd0;

  gcol_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gcol_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_data      (in_data),
    .vertex_count (vcount_r),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_data     (out_data)
  );

`ifndef NO_ASSERTIONS
  // Items are handled one at a time: a transfer is never followed at once by another.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted in two consecutive cycles");

  // The reported count of colors always covers the color just given.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.colors_used > {1'b0, out_data.assigned_color}))
    else $error("colors_used does not exceed assigned_color");

  // Reset starts the clearing pass, so no item may be taken right after it.
  assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("block ready or holding a result right after reset");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_greedy_graph_colorer.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for greedy_graph_colorer: a queue-fed driver, a checking monitor
// and an item-level predictor of the adjacency store and vertex colors.
// Depends on gcol_pkg and the greedy_graph_colorer RTL only.
module tb_greedy_graph_colorer;

  localparam int VERTS          = 256;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] VCOUNT_ADDR = 3'(4 * gcol_pkg::REG_VERTEX_COUNT);
  localparam int HOLD_CYCLES    = 3000;
  localparam int SETTLE_CYCLES  = 300;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS    = 80;
  localparam int PHASE_EPISODES = 25;
  localparam int MAX_REPORTS    = 100;
  localparam int NUM_PHASES     = 12;
  localparam int CLIQUE_SIZE    = 24;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  gcol_pkg::gcol_in_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  gcol_pkg::gcol_out_t out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // Predicted graph state and configuration.
  bit [VERTS-1:0]                adj_rows [VERTS];
  bit [gcol_pkg::COLOR_W-1:0]    color_of [VERTS];
  bit                            is_colored [VERTS];
  bit [gcol_pkg::COLOR_W-1:0]    top_color;
  bit [gcol_pkg::VCOUNT_W-1:0]   cfg_vertex_count = gcol_pkg::VCOUNT_RESET;

  gcol_pkg::gcol_in_t  pending_items [$];
  gcol_pkg::gcol_out_t color_expect_q [$];

  bit [gcol_pkg::VCOUNT_W-1:0] phase_counts [NUM_PHASES] =
    '{9'd256, 9'd1, 9'd5, 9'd0, 9'd16, 9'd511, 9'd3, 9'd300, 9'd12, 9'd2, 9'd64, 9'd8};

  int                  mismatches;
  int                  items_accepted;
  int                  colorings_checked;
  int                  settings_written;
  int                  saturations;
  int                  real_items;
  int                  send_idle_pct = 13;
  int                  recv_idle_pct = 75;
  int                  hold_req;
  int                  hold_taken;
  int                  hold_left;
  int                  quiet_cycles;
  bit [gcol_pkg::COLOR_W-1:0] largest_color;

  greedy_graph_colorer #(
    .MAX_VERTICES(VERTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  function automatic int live_vertices();
    return (cfg_vertex_count > VERTS) ? VERTS : int'(cfg_vertex_count);
  endfunction

  function automatic int pick_vertex(input int n);
    if (n == 0 || $urandom_range(9) == 0) return $urandom_range(VERTS - 1);
    return $urandom_range(n - 1);
  endfunction

  function automatic void queue_item(input logic [1:0] op, input int a, input int b);
    gcol_pkg::gcol_in_t item;
    int n;
    n = live_vertices();
    item.op = op;
    item.vertex_a = gcol_pkg::VERTEX_W'(a);
    item.vertex_b = gcol_pkg::VERTEX_W'(b);
    if (op == gcol_pkg::OP_CLEAR || (op == gcol_pkg::OP_COLOR && a < n) ||
        (op == gcol_pkg::OP_ADD_EDGE && a < n && b < n))
      real_items++;
    pending_items.insert(pending_items.size(), item);
  endfunction

  // Applies one accepted item to the predicted state; an in-range coloring yields one expected result.
  function automatic void predict_item(input gcol_pkg::gcol_in_t item);
    int n;
    int u;
    int c;
    bit [gcol_pkg::NUM_COLORS-1:0] blocked;
    gcol_pkg::gcol_out_t r;
    n = live_vertices();
    case (item.op)
      gcol_pkg::OP_ADD_EDGE: begin
        if (item.vertex_a < n && item.vertex_b < n) begin
          adj_rows[item.vertex_a][item.vertex_b] = 1'b1;
          adj_rows[item.vertex_b][item.vertex_a] = 1'b1;
        end
      end
      gcol_pkg::OP_CLEAR: begin
        foreach (adj_rows[i]) adj_rows[i] = '0;
        foreach (color_of[i]) color_of[i] = '0;
        foreach (is_colored[i]) is_colored[i] = 1'b0;
        top_color = '0;
      end
      gcol_pkg::OP_COLOR: begin
        if (item.vertex_a < n) begin
          blocked = '0;
          for (u = 0; u < n; u++)
            if (is_colored[u] && adj_rows[item.vertex_a][u]) blocked[color_of[u]] = 1'b1;
          c = 0;
          while (c < gcol_pkg::COLOR_SAT && blocked[c]) c++;
          // Stopping at the top color with it blocked means every color was taken.
          if (blocked[c]) saturations++;
          color_of[item.vertex_a] = gcol_pkg::COLOR_W'(c);
          is_colored[item.vertex_a] = 1'b1;
          if (c > top_color) top_color = gcol_pkg::COLOR_W'(c);
          r.colored_vertex = item.vertex_a;
          r.assigned_color = gcol_pkg::COLOR_W'(c);
          r.colors_used = {1'b0, top_color} + 9'd1;
          color_expect_q.insert(color_expect_q.size(), r);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_REPORTS) $display("[%0t] MISMATCH: %s", $time, what);
    mismatches++;
  endtask

  // Waits until every item has been taken and every coloring returned, then lets
  // a trailing clear or edge update that produces no result run out.
  task automatic settle();
    while (pending_items.size() != 0 || in_valid || color_expect_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(input bit [gcol_pkg::VCOUNT_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= VCOUNT_ADDR;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_vertex_count = value;
    settings_written++;
  endtask

  always @(posedge clk) begin : driver
    bit may_load;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      may_load = !in_valid;
      if (in_valid && in_ready) begin
        predict_item(in_data);
        items_accepted++;
        may_load = 1'b1;
      end
      if (may_load) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // A requested hold-off keeps out_ready low for a long stretch so the block backs up.
  always @(posedge clk) begin : receiver
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_req) begin
      hold_taken <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    gcol_pkg::gcol_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (color_expect_q.size() == 0) begin
        report_mismatch($sformatf("result for vertex %0d with no coloring pending",
                                  out_data.colored_vertex));
      end else begin
        want = color_expect_q.pop_front();
        if (out_data.colored_vertex !== want.colored_vertex)
          report_mismatch($sformatf("colored_vertex got %0d, expected %0d",
                                    out_data.colored_vertex, want.colored_vertex));
        if (out_data.assigned_color !== want.assigned_color)
          report_mismatch($sformatf("assigned_color of vertex %0d got %0d, expected %0d",
                                    want.colored_vertex, out_data.assigned_color,
                                    want.assigned_color));
        if (out_data.colors_used !== want.colors_used)
          report_mismatch($sformatf("colors_used after vertex %0d got %0d, expected %0d",
                                    want.colored_vertex, out_data.colors_used,
                                    want.colors_used));
        if (want.assigned_color > largest_color) largest_color = want.assigned_color;
        colorings_checked++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int p;
    int ne;
    int k;
    int episodes;
    int a;
    int b;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset vertex count: extreme vertices, self-loops,
    // recoloring, a duplicate edge, the unused op and a clear.
    queue_item(gcol_pkg::OP_COLOR, 0, 0);
    queue_item(gcol_pkg::OP_COLOR, 255, 255);
    queue_item(gcol_pkg::OP_ADD_EDGE, 0, 255);
    queue_item(gcol_pkg::OP_COLOR, 255, 0);
    queue_item(gcol_pkg::OP_ADD_EDGE, 7, 7);
    queue_item(gcol_pkg::OP_COLOR, 7, 0);
    queue_item(gcol_pkg::OP_COLOR, 7, 0);
    queue_item(gcol_pkg::OP_ADD_EDGE, 255, 255);
    queue_item(gcol_pkg::OP_ADD_EDGE, 255, 0);
    queue_item(gcol_pkg::OP_COLOR, 255, 0);
    queue_item(OP_UNUSED, 255, 255);
    queue_item(gcol_pkg::OP_ADD_EDGE, 0, 0);
    queue_item(gcol_pkg::OP_COLOR, 0, 255);
    queue_item(gcol_pkg::OP_CLEAR, 255, 255);
    queue_item(gcol_pkg::OP_COLOR, 255, 0);
    settle();
    // One vertex in use: out-of-range endpoints and vertices are ignored.
    write_vertex_count(9'd1);
    queue_item(gcol_pkg::OP_ADD_EDGE, 0, 1);
    queue_item(gcol_pkg::OP_COLOR, 1, 0);
    queue_item(gcol_pkg::OP_ADD_EDGE, 0, 0);
    queue_item(gcol_pkg::OP_COLOR, 0, 0);
    queue_item(gcol_pkg::OP_COLOR, 0, 0);
    settle();
    // No vertex in use at all.
    write_vertex_count(9'd0);
    queue_item(gcol_pkg::OP_ADD_EDGE, 0, 0);
    queue_item(gcol_pkg::OP_COLOR, 0, 0);
    settle();

    for (p = 0; p < NUM_PHASES; p++) begin
      if (p == 4) begin
        send_idle_pct = 75;
        recv_idle_pct = 13;
        hold_req++;
      end
      if (p == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_vertex_count(phase_counts[p]);
      real_items = 0;
      episodes = 0;
      // Each episode builds some graph, then colors vertices in a random order.
      while (real_items < PHASE_ITEMS && episodes < PHASE_EPISODES) begin
        ne = live_vertices();
        if ($urandom_range(4) == 0)
          queue_item(gcol_pkg::OP_CLEAR, $urandom_range(255), $urandom_range(255));
        k = (ne == 0) ? 4 : $urandom_range(1, (ne < 12) ? 3 * ne : 36);
        repeat (k) queue_item(gcol_pkg::OP_ADD_EDGE, pick_vertex(ne), pick_vertex(ne));
        k = $urandom_range(1, (ne < 20) ? ne + 2 : 24);
        repeat (k) queue_item(gcol_pkg::OP_COLOR, pick_vertex(ne), $urandom_range(255));
        if ($urandom_range(5) == 0)
          queue_item(OP_UNUSED, $urandom_range(255), $urandom_range(255));
        episodes++;
      end
      settle();
    end

    // A clique colored in index order gives each vertex its index as color;
    // recoloring the self-looped vertex 0 then finds every clique color blocked.
    write_vertex_count(gcol_pkg::VCOUNT_RESET);
    queue_item(gcol_pkg::OP_CLEAR, 0, 0);
    for (a = 1; a < CLIQUE_SIZE; a++)
      for (b = 0; b < a; b++)
        queue_item(gcol_pkg::OP_ADD_EDGE, a, b);
    queue_item(gcol_pkg::OP_ADD_EDGE, 0, 0);
    for (a = 0; a < CLIQUE_SIZE; a++) queue_item(gcol_pkg::OP_COLOR, a, 0);
    queue_item(gcol_pkg::OP_COLOR, 0, 0);
    settle();

    if (color_expect_q.size() != 0)
      report_mismatch($sformatf("%0d colorings never returned", color_expect_q.size()));
    $display("Summary: %0d items accepted over %0d vertex-count settings, %0d colorings checked.",
             items_accepted, settings_written, colorings_checked);
    $display("Summary: largest color returned %0d, all colors blocked %0d time(s), %0d mismatches.",
             largest_color, saturations, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
